### rtl/box_filter_3x3_zero_pad_defines.svh
// Assertion macros used by the checker.
`ifndef BOX_FILTER_3X3_ZERO_PAD_DEFINES_SVH
`define BOX_FILTER_3X3_ZERO_PAD_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define BFZ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("box filter check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define BFZ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("box filter check failed");

`endif

### rtl/bfz_pkg.sv
package bfz_pkg;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 1024;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int PIX_W   = 8;
  localparam int COORD_W = 10;
  localparam int SUM_W   = 12;
  localparam int MEAN_W  = 16;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int LB_W    = 2 * PIX_W;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     SIZE_RESET     = CFG_W'(1024);

  // result kinds, in release order
  localparam int NUM_KINDS = 4;
  localparam logic [1:0] RES_UL   = 2'd0;  // (r-1, c-1)
  localparam logic [1:0] RES_UP   = 2'd1;  // (r-1, c) at row end
  localparam logic [1:0] RES_LEFT = 2'd2;  // (r, c-1) on last row
  localparam logic [1:0] RES_HERE = 2'd3;  // (r, c) at frame end

  // floor(x*256/9) == (x * MEAN_MUL) >> MEAN_SHIFT for x < 2^12
  localparam logic [31:0] MEAN_MUL   = 32'd932068;
  localparam int          MEAN_SHIFT = 15;

  typedef struct packed {
    logic [COORD_W-1:0]              row;
    logic [COORD_W-1:0]              col;
    logic [NUM_KINDS-1:0]            mask;
    logic [NUM_KINDS-1:0][SUM_W-1:0] sums;
  } job_t;

endpackage

### rtl/bfz_if.sv
interface bfz_pix_if;
  logic                      valid;
  logic                      ready;
  logic [bfz_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface bfz_res_if;
  logic                        valid;
  logic                        ready;
  logic [bfz_pkg::COORD_W-1:0] out_row;
  logic [bfz_pkg::COORD_W-1:0] out_col;
  logic [bfz_pkg::SUM_W-1:0]   window_sum;
  logic [bfz_pkg::MEAN_W-1:0]  mean_q8;
  logic                        last_of_run;

  modport source (output valid, output out_row, output out_col, output window_sum,
                  output mean_q8, output last_of_run, input ready);
  modport sink   (input valid, input out_row, input out_col, input window_sum,
                  input mean_q8, input last_of_run, output ready);
endinterface

interface bfz_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bfz_pkg::CFG_IDX_W-1:0] index;
  logic [bfz_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/bfz_ram.sv
module bfz_ram #(
  parameter int WIDTH = bfz_pkg::LB_W,
  parameter int DEPTH = bfz_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/bfz_front.sv
module bfz_front #(
  parameter int MAX_WIDTH   = bfz_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = bfz_pkg::MAX_HEIGHT_DEF,
  parameter int QUEUE_DEPTH = bfz_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  bfz_pix_if.sink                            pix_i,
  bfz_cfg_if.sink                            cfg_i,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_count_i,
  output logic                               push_o,
  output bfz_pkg::job_t                      job_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = bfz_pkg::PIX_W;

  logic [bfz_pkg::CFG_W-1:0] rows_cfg_q, cols_cfg_q;
  logic [HW-1:0]             rows_eff;
  logic [WW-1:0]             cols_eff;

  logic [RW-1:0] row_q, row_d, r0;
  logic [CW-1:0] col_q, col_d, c0;
  logic          wrap, row_last, col_last, r_nz, c_nz;
  logic          accept;
  logic [bfz_pkg::NUM_KINDS-1:0] mask0;

  logic                          s1_valid_q;
  logic [CW-1:0]                 s1_c_q;
  logic                          s1_r_nz_q, s1_r_ge2_q, s1_c_zero_q;
  logic [PW-1:0]                 s1_pix_q;
  logic [bfz_pkg::NUM_KINDS-1:0] s1_mask_q;
  logic [bfz_pkg::COORD_W-1:0]   s1_row_q, s1_col_q;
  logic                          fwd_q;
  logic [bfz_pkg::LB_W-1:0]      wr_last_q, ram_rd, lb, wdata;
  logic [PW-1:0]                 up1, up2;

  logic [2:0][2:0][PW-1:0] win_q, win_d, base;
  logic [2:0][PW:0]        tsum;
  logic [2:0][PW+1:0]      csum;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= bfz_pkg::SIZE_RESET;
      cols_cfg_q <= bfz_pkg::SIZE_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == bfz_pkg::REG_FRAME_ROWS) begin
        rows_cfg_q <= cfg_i.data;
      end
      if (cfg_i.index == bfz_pkg::REG_FRAME_COLS) begin
        cols_cfg_q <= cfg_i.data;
      end
    end
  end

  always_comb begin
    if (rows_cfg_q == '0) begin
      rows_eff = HW'(1);
    end else if (32'(rows_cfg_q) > 32'(MAX_HEIGHT)) begin
      rows_eff = HW'(MAX_HEIGHT);
    end else begin
      rows_eff = HW'(rows_cfg_q);
    end
    if (cols_cfg_q == '0) begin
      cols_eff = WW'(1);
    end else if (32'(cols_cfg_q) > 32'(MAX_WIDTH)) begin
      cols_eff = WW'(MAX_WIDTH);
    end else begin
      cols_eff = WW'(cols_cfg_q);
    end
  end

  // classify the incoming word
  assign wrap     = (HW'(row_q) >= rows_eff) || (WW'(col_q) >= cols_eff);
  assign r0       = wrap ? '0 : row_q;
  assign c0       = wrap ? '0 : col_q;
  assign row_last = (HW'(r0) + HW'(1)) == rows_eff;
  assign col_last = (WW'(c0) + WW'(1)) == cols_eff;
  assign r_nz     = r0 != '0;
  assign c_nz     = c0 != '0;
  assign mask0    = {row_last & col_last, row_last & c_nz, r_nz & col_last, r_nz & c_nz};

  assign pix_i.ready = (32'(q_count_i) + 32'(s1_valid_q)) < 32'(QUEUE_DEPTH);
  assign accept      = pix_i.valid && pix_i.ready;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (accept) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : r0 + RW'(1);
      end else begin
        col_d = c0 + CW'(1);
        row_d = r0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      win_q      <= '0;
    end else begin
      row_q      <= row_d;
      col_q      <= col_d;
      s1_valid_q <= accept;
      fwd_q      <= s1_valid_q && (s1_c_q == c0);
      win_q      <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_c_q      <= c0;
      s1_r_nz_q   <= r_nz;
      s1_r_ge2_q  <= r0 > RW'(1);
      s1_c_zero_q <= !c_nz;
      s1_pix_q    <= pix_i.pixel;
      s1_mask_q   <= mask0;
      s1_row_q    <= bfz_pkg::COORD_W'(r0);
      s1_col_q    <= bfz_pkg::COORD_W'(c0);
    end
    if (s1_valid_q) begin
      wr_last_q <= wdata;
    end
  end

  // line buffers: {two rows above, one row above}
  bfz_ram #(
    .WIDTH(bfz_pkg::LB_W),
    .DEPTH(MAX_WIDTH)
  ) u_lb (
    .clk_i  (clk_i),
    .we_i   (s1_valid_q),
    .waddr_i(s1_c_q),
    .wdata_i(wdata),
    .raddr_i(c0),
    .rdata_o(ram_rd)
  );

  assign lb    = fwd_q ? wr_last_q : ram_rd;
  assign wdata = {lb[PW-1:0], s1_pix_q};
  assign up1   = s1_r_nz_q  ? lb[PW-1:0]    : '0;
  assign up2   = s1_r_ge2_q ? lb[2*PW-1:PW] : '0;

  always_comb begin
    win_d = win_q;
    base  = s1_c_zero_q ? '0 : win_q;
    if (s1_valid_q) begin
      for (int i = 0; i < 3; i++) begin
        win_d[i][0] = base[i][1];
        win_d[i][1] = base[i][2];
      end
      win_d[0][2] = up2;
      win_d[1][2] = up1;
      win_d[2][2] = s1_pix_q;
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      tsum[j] = (PW+1)'(win_d[1][j]) + (PW+1)'(win_d[2][j]);
      csum[j] = (PW+2)'(tsum[j]) + (PW+2)'(win_d[0][j]);
    end
  end

  assign push_o     = s1_valid_q && (s1_mask_q != '0);
  assign job_o.row  = s1_row_q;
  assign job_o.col  = s1_col_q;
  assign job_o.mask = s1_mask_q;
  assign job_o.sums[bfz_pkg::RES_UL]   = bfz_pkg::SUM_W'(csum[0]) + bfz_pkg::SUM_W'(csum[1])
                                       + bfz_pkg::SUM_W'(csum[2]);
  assign job_o.sums[bfz_pkg::RES_UP]   = bfz_pkg::SUM_W'(csum[1]) + bfz_pkg::SUM_W'(csum[2]);
  assign job_o.sums[bfz_pkg::RES_LEFT] = bfz_pkg::SUM_W'(tsum[0]) + bfz_pkg::SUM_W'(tsum[1])
                                       + bfz_pkg::SUM_W'(tsum[2]);
  assign job_o.sums[bfz_pkg::RES_HERE] = bfz_pkg::SUM_W'(tsum[1]) + bfz_pkg::SUM_W'(tsum[2]);

endmodule

### rtl/bfz_queue.sv
module bfz_queue #(
  parameter int DEPTH = bfz_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  bfz_pkg::job_t                job_i,
  input  logic                         pop_i,
  output bfz_pkg::job_t                head_o,
  output logic                         head_valid_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  bfz_pkg::job_t   mem_q [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [NW-1:0]   cnt_q;
  logic            do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      cnt_q <= cnt_q + NW'(push_i) - NW'(do_pop);
    end
  end

  assign head_o       = mem_q[rd_q];
  assign head_valid_o = cnt_q != '0;
  assign count_o      = cnt_q;

endmodule

### rtl/bfz_back.sv
module bfz_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bfz_pkg::job_t head_i,
  input  logic          head_valid_i,
  output logic          pop_o,
  bfz_res_if.source     res_o
);

  logic [bfz_pkg::NUM_KINDS-1:0] done_q, act, selbit;
  logic [1:0]                    sel;
  logic                          last, load, out_valid_q;
  logic [bfz_pkg::COORD_W-1:0]   row_q, col_q, row_n, col_n;
  logic [bfz_pkg::SUM_W-1:0]     sum_q, sum_n;
  logic [31:0]                   prod;
  logic [bfz_pkg::MEAN_W-1:0]    mean_q;
  logic                          last_q;

  assign act = head_i.mask & ~done_q;

  always_comb begin
    if (act[bfz_pkg::RES_UL]) begin
      sel = bfz_pkg::RES_UL;
    end else if (act[bfz_pkg::RES_UP]) begin
      sel = bfz_pkg::RES_UP;
    end else if (act[bfz_pkg::RES_LEFT]) begin
      sel = bfz_pkg::RES_LEFT;
    end else begin
      sel = bfz_pkg::RES_HERE;
    end
  end

  assign selbit = bfz_pkg::NUM_KINDS'(1) << sel;
  assign last   = (act & ~selbit) == '0;
  assign load   = head_valid_i && (!out_valid_q || res_o.ready);
  assign pop_o  = load && last;

  assign row_n = (sel == bfz_pkg::RES_UL || sel == bfz_pkg::RES_UP)
               ? head_i.row - bfz_pkg::COORD_W'(1) : head_i.row;
  assign col_n = (sel == bfz_pkg::RES_UL || sel == bfz_pkg::RES_LEFT)
               ? head_i.col - bfz_pkg::COORD_W'(1) : head_i.col;
  assign sum_n = head_i.sums[sel];
  assign prod  = 32'(sum_n) * bfz_pkg::MEAN_MUL;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      done_q      <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        done_q      <= last ? '0 : (done_q | selbit);
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      row_q  <= row_n;
      col_q  <= col_n;
      sum_q  <= sum_n;
      mean_q <= prod[bfz_pkg::MEAN_SHIFT +: bfz_pkg::MEAN_W];
      last_q <= last;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.out_row     = row_q;
  assign res_o.out_col     = col_q;
  assign res_o.window_sum  = sum_q;
  assign res_o.mean_q8     = mean_q;
  assign res_o.last_of_run = last_q;

endmodule

### rtl/box_filter_3x3_zero_pad.sv
// An accepted pixel reaches the output via the stage-1 registers and job queue.
// Throughput: one pixel per cycle while the queue has room; results leave at one
//   per cycle while res_o is ready, and a pixel releases up to 4 results.
// Reset: async, active low; clears counters, window and queue, sets the frame
//   size to 1024x1024. Line buffers are not cleared.
module box_filter_3x3_zero_pad #(
  parameter int MAX_WIDTH   = bfz_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = bfz_pkg::MAX_HEIGHT_DEF,
  parameter int QUEUE_DEPTH = bfz_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfz_pix_if.sink    pix_i,
  bfz_cfg_if.sink    cfg_i,
  bfz_res_if.source  res_o
);

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  logic              push, pop, head_valid;
  logic [QCW-1:0]    q_count;
  bfz_pkg::job_t     job, head;

  bfz_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pix_i    (pix_i),
    .cfg_i    (cfg_i),
    .q_count_i(q_count),
    .push_o   (push),
    .job_o    (job)
  );

  bfz_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .job_i       (job),
    .pop_i       (pop),
    .head_o      (head),
    .head_valid_o(head_valid),
    .count_o     (q_count)
  );

  bfz_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .head_valid_i(head_valid),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule

### rtl/bfz_checker.sv
`include "box_filter_3x3_zero_pad_defines.svh"

module bfz_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [bfz_pkg::COORD_W-1:0] out_row,
  input logic [bfz_pkg::COORD_W-1:0] out_col,
  input logic [bfz_pkg::SUM_W-1:0]   window_sum,
  input logic [bfz_pkg::MEAN_W-1:0]  mean_q8,
  input logic                        last_of_run
);

  `BFZ_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(out_row) && $stable(out_col) && $stable(window_sum) && $stable(mean_q8) && $stable(last_of_run))

  `BFZ_ASSERT_IMP(a_mean_exact, res_valid, (32'(mean_q8) * 32'd9 <= 32'(window_sum) * 32'd256) && (32'(window_sum) * 32'd256 < 32'(mean_q8) * 32'd9 + 32'd9))

  `BFZ_ASSERT_NXT(a_run_continues, res_valid && res_ready && !last_of_run, res_valid)

endmodule

bind box_filter_3x3_zero_pad bfz_checker u_bfz_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .res_valid  (res_o.valid),
  .res_ready  (res_o.ready),
  .out_row    (res_o.out_row),
  .out_col    (res_o.out_col),
  .window_sum (res_o.window_sum),
  .mean_q8    (res_o.mean_q8),
  .last_of_run(res_o.last_of_run)
);
